>>> src/lssched_pkg.sv
// Package for the least-slack multi-CPU scheduler.
// Holds the request/result structs, event codes and sizing constants.
package lssched_pkg;

  localparam int unsigned MaxCpusDef    = 8;
  localparam int unsigned ReadyDepthDef = 16;
  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned CfgIdxW       = 1;
  localparam int unsigned CfgDataW      = 10;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_ARRIVE = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [0:0] {
    CFG_CPU_COUNT = 1'b0,
    CFG_MIN_REM   = 1'b1
  } cfg_idx_t;

  typedef enum logic [0:0] {
    ST_DISPATCH = 1'b0,
    ST_DROPPED  = 1'b1
  } status_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  job_id;
    logic [31:0] job_deadline;
    logic [31:0] job_duration;
    logic [2:0]  done_cpu;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic [2:0] cpu;
    logic [7:0] dispatched_id;
    logic       last;
  } out_item_t;

  // Back-end phases.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ARRIVE,
    BK_PREEMPT,
    BK_SCAN,
    BK_ASSIGN,
    BK_FINISH
  } bk_state_t;

endpackage

>>> src/least_slack_multi_cpu_scheduler_unit.sv
// Least-slack scheduler for up to MAX_CPUS CPUs with a READY_DEPTH-entry ready table.
// A completion's processing time is set by the serial slot scan per free CPU; an arrival
// that finds no free CPU first walks the CPUs and preempts the busy ones while the ready
// table has room, then runs the same scan.
// One event is processed at a time; a two-entry request queue absorbs bursts.
// Synchronous active-low reset clears the clock, table valids and CPU busy bits.
// Results are strobed for one cycle; the receiver cannot stall.
module least_slack_multi_cpu_scheduler_unit import lssched_pkg::*; #(
  parameter int unsigned MAX_CPUS    = MaxCpusDef,
  parameter int unsigned READY_DEPTH = ReadyDepthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  in_item_t            in_req,
  output logic                out_valid,
  output out_item_t           out_res,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_data
);

  logic [3:0] cpu_count_r;
  logic [9:0] min_rem_r;
  logic       q_valid, q_pop;
  in_item_t   q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_count_r <= 4'd1;
      min_rem_r   <= 10'd10;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_CPU_COUNT: cpu_count_r <= cfg_data[3:0];
        CFG_MIN_REM:   min_rem_r   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  lssched_front u_front (
    .clk, .rst_n, .start, .busy, .in_req,
    .q_valid, .q_item, .q_pop
  );

  lssched_back #(.MAX_CPUS(MAX_CPUS), .READY_DEPTH(READY_DEPTH)) u_back (
    .clk, .rst_n,
    .cpu_count(cpu_count_r), .min_remaining(min_rem_r),
    .q_valid, .q_item, .q_pop, .out_valid, .out_res
  );

  a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_drop_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status) |-> out_res.last) else $error("drop not last");
  a_drop_cpu_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status) |-> (out_res.cpu == 3'd0)) else $error("drop cpu");

endmodule

>>> src/lssched_front.sv
// Front end: takes requests and keeps them in a short queue for the back end.
// Depends on lssched_pkg.
module lssched_front import lssched_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_item_t in_req,
  output logic     q_valid,
  output in_item_t q_item,
  input  logic     q_pop
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  in_item_t         mem_r [QueueDepth];
  logic [PtrW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PtrW:0]    cnt_r, cnt_nxt;
  logic             push;

  assign busy    = (cnt_r == PtrW'(0) + (PtrW+1)'(QueueDepth));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = (q_pop && q_valid) ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (PtrW+1)'(push) - (PtrW+1)'(q_pop && q_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_req;
  end

endmodule

>>> src/lssched_back.sv
// Back end: ready table, CPU state, preemption and least-slack dispatch.
// Depends on lssched_pkg.
module lssched_back import lssched_pkg::*; #(
  parameter int unsigned MAX_CPUS    = MaxCpusDef,
  parameter int unsigned READY_DEPTH = ReadyDepthDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [3:0] cpu_count,
  input  logic [9:0] min_remaining,
  input  logic       q_valid,
  input  in_item_t   q_item,
  output logic       q_pop,
  output logic       out_valid,
  output out_item_t  out_res
);

  localparam int unsigned SW = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
  localparam int unsigned CW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;

  bk_state_t st_r, st_nxt;
  in_item_t  it_r;
  logic [31:0] now_r;
  logic [READY_DEPTH-1:0] rv_r;
  logic [7:0]  rid_r [READY_DEPTH];
  logic [31:0] rdl_r [READY_DEPTH];
  logic [31:0] rrem_r [READY_DEPTH];
  logic [MAX_CPUS-1:0] busy_r;
  logic [7:0]  cid_r [MAX_CPUS];
  logic [31:0] cdl_r [MAX_CPUS];
  logic [31:0] crem_r [MAX_CPUS];
  logic [31:0] cst_r [MAX_CPUS];

  logic [CW:0] c_r;            // CPU walker, one wider to hold the count
  logic [SW:0] s_r;            // slot walker
  logic        bfound_r;
  logic [SW-1:0] bslot_r;
  logic signed [33:0] bslk_r;
  logic        any_r;
  logic        have_r;
  logic [2:0]  pcpu_r;
  logic [7:0]  pid_r;

  logic [CW:0]  ncpu;
  logic [31:0]  floor_v;
  logic         full;
  logic [SW-1:0] fslot;
  logic         any_free;
  logic [CW-1:0] ci;
  logic [SW-1:0] si;
  logic signed [33:0] slk;
  logic [31:0]  elapsed, rem_v;
  logic         ov_nxt;

  always_comb begin
    if (cpu_count == 4'd0) ncpu = (CW+1)'(1);
    else if (32'(cpu_count) > MAX_CPUS) ncpu = (CW+1)'(MAX_CPUS);
    else ncpu = (CW+1)'(cpu_count);
    floor_v = (min_remaining == 10'd0) ? 32'd1 : 32'(min_remaining);
    full  = &rv_r;
    fslot = '0;
    for (int i = READY_DEPTH-1; i >= 0; i--) if (!rv_r[i]) fslot = SW'(i);
    any_free = 1'b0;
    for (int i = 0; i < MAX_CPUS; i++)
      if ((CW+1)'(i) < ncpu && !busy_r[i]) any_free = 1'b1;
    ci = c_r[CW-1:0];
    si = s_r[SW-1:0];
    slk = $signed({2'b00, rdl_r[si]}) - $signed({2'b00, now_r})
        - $signed({2'b00, rrem_r[si]});
    elapsed = now_r - cst_r[ci];
    if (elapsed >= crem_r[ci]) rem_v = floor_v;
    else rem_v = crem_r[ci] - elapsed;
    if (rem_v < floor_v) rem_v = floor_v;
  end

  // Next-state logic.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: if (q_valid) st_nxt = BK_ARRIVE;
      BK_ARRIVE: begin
        case (kind_t'(it_r.kind))
          KIND_ARRIVE: st_nxt = full ? BK_IDLE : BK_PREEMPT;
          KIND_DONE:   st_nxt = (32'(it_r.done_cpu) >= MAX_CPUS) ? BK_IDLE : BK_SCAN;
          default:     st_nxt = BK_IDLE;
        endcase
      end
      BK_PREEMPT: if (!any_r || c_r >= ncpu || full) st_nxt = BK_SCAN;
      BK_SCAN: begin
        if (c_r >= ncpu) st_nxt = BK_FINISH;
        else if (!busy_r[ci] && s_r >= (SW+1)'(READY_DEPTH))
          st_nxt = bfound_r ? BK_ASSIGN : BK_FINISH;
      end
      BK_ASSIGN: st_nxt = BK_SCAN;
      BK_FINISH: st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  // Output strobe: a drop, or a held dispatch flushed by the next assign or the finish.
  always_comb begin
    ov_nxt = ((st_r == BK_ARRIVE) && (kind_t'(it_r.kind) == KIND_ARRIVE) && full) ||
             (((st_r == BK_ASSIGN) || (st_r == BK_FINISH)) && have_r);
  end

  assign q_pop = (st_r == BK_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      now_r <= '0;
      rv_r <= '0;
      busy_r <= '0;
      out_valid <= 1'b0;
      have_r <= 1'b0;
      c_r <= '0;
      s_r <= '0;
      bfound_r <= 1'b0;
      any_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_valid <= ov_nxt;
      case (st_r)
        BK_IDLE: begin
          if (q_valid) it_r <= q_item;
          have_r <= 1'b0;
          c_r <= '0;
          s_r <= '0;
          bfound_r <= 1'b0;
        end
        BK_ARRIVE: begin
          case (kind_t'(it_r.kind))
            KIND_TICK: now_r <= now_r + 32'd1;
            KIND_ARRIVE: begin
              if (full) begin
                out_res <= '{status: ST_DROPPED, cpu: 3'd0,
                             dispatched_id: it_r.job_id, last: 1'b1};
              end else begin
                rv_r[fslot] <= 1'b1;
                rid_r[fslot] <= it_r.job_id;
                rdl_r[fslot] <= it_r.job_deadline;
                rrem_r[fslot] <= it_r.job_duration;
                any_r <= !any_free;
              end
            end
            KIND_DONE: begin
              if (32'(it_r.done_cpu) < MAX_CPUS) busy_r[CW'(it_r.done_cpu)] <= 1'b0;
            end
            default: ;
          endcase
        end
        BK_PREEMPT: begin
          if (any_r && c_r < ncpu && !full) begin
            if (busy_r[ci]) begin
              rv_r[fslot] <= 1'b1;
              rid_r[fslot] <= cid_r[ci];
              rdl_r[fslot] <= cdl_r[ci];
              rrem_r[fslot] <= rem_v;
              busy_r[ci] <= 1'b0;
            end
            c_r <= c_r + 1'b1;
          end else begin
            c_r <= '0;
          end
        end
        BK_SCAN: begin
          // Walk CPUs; on a free one, scan all slots for the least slack.
          if (c_r < ncpu) begin
            if (busy_r[ci]) begin
              c_r <= c_r + 1'b1;
            end else if (s_r < (SW+1)'(READY_DEPTH)) begin
              if (rv_r[si] && (!bfound_r || slk < bslk_r)) begin
                bfound_r <= 1'b1;
                bslot_r <= si;
                bslk_r <= slk;
              end
              s_r <= s_r + 1'b1;
            end
          end
        end
        BK_ASSIGN: begin
          if (have_r) begin
            out_res <= '{status: ST_DISPATCH, cpu: pcpu_r, dispatched_id: pid_r,
                         last: 1'b0};
          end
          have_r <= 1'b1;
          pcpu_r <= 3'(ci);
          pid_r <= rid_r[bslot_r];
          busy_r[ci] <= 1'b1;
          cid_r[ci] <= rid_r[bslot_r];
          cdl_r[ci] <= rdl_r[bslot_r];
          crem_r[ci] <= rrem_r[bslot_r];
          cst_r[ci] <= now_r;
          rv_r[bslot_r] <= 1'b0;
          c_r <= c_r + 1'b1;
          s_r <= '0;
          bfound_r <= 1'b0;
        end
        BK_FINISH: begin
          if (have_r) begin
            out_res <= '{status: ST_DISPATCH, cpu: pcpu_r, dispatched_id: pid_r,
                         last: 1'b1};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> tb/sv/tb_least_slack_multi_cpu_scheduler_unit.sv
// Self-checking testbench for the least-slack multi-CPU scheduler.
// Predicts every dispatch and drop from the accepted events and compares them in order.
// Depends on lssched_pkg and least_slack_multi_cpu_scheduler_unit.
module tb_least_slack_multi_cpu_scheduler_unit;
  import lssched_pkg::*;

  localparam int NCPU       = 8;
  localparam int NSLOT      = 16;
  localparam int DRAIN_WAIT = 300;
  localparam int STALL_MAX  = 20000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  in_item_t            in_req = '0;
  logic                out_valid;
  out_item_t           out_res;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  least_slack_multi_cpu_scheduler_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Shadow scheduler state.
  logic [3:0]  sh_cpus = 4'd1;
  logic [9:0]  sh_floor = 10'd10;
  logic [31:0] sh_now = '0;
  logic        rdy_v [NSLOT];
  logic [7:0]  rdy_id [NSLOT];
  logic [31:0] rdy_dl [NSLOT];
  logic [31:0] rdy_rem [NSLOT];
  logic        run_v [NCPU];
  logic [7:0]  run_id [NCPU];
  logic [31:0] run_dl [NCPU];
  logic [31:0] run_rem [NCPU];
  logic [31:0] run_t0 [NCPU];

  in_item_t  req_q [$];
  out_item_t sched_q [$];
  int        idle_pct = 0;
  int        errors = 0;
  int        stall_cnt = 0;
  bit        taken = 1'b0;

  initial begin
    for (int i = 0; i < NSLOT; i++) rdy_v[i] = 1'b0;
    for (int i = 0; i < NCPU; i++) run_v[i] = 1'b0;
  end

  function automatic int active_cpus();
    if (sh_cpus == 0) return 1;
    if (sh_cpus > NCPU) return NCPU;
    return sh_cpus;
  endfunction

  function automatic int open_slot();
    for (int s = 0; s < NSLOT; s++) if (!rdy_v[s]) return s;
    return -1;
  endfunction

  function automatic void run_dispatch();
    int        best;
    longint    bs, sl;
    int        k;
    out_item_t r;
    k = 0;
    for (int c = 0; c < active_cpus(); c++) begin
      if (run_v[c]) continue;
      best = -1;
      bs = 0;
      for (int s = 0; s < NSLOT; s++) begin
        if (!rdy_v[s]) continue;
        sl = longint'(rdy_dl[s]) - longint'(sh_now) - longint'(rdy_rem[s]);
        if (best < 0 || sl < bs) begin
          best = s;
          bs = sl;
        end
      end
      if (best < 0) break;
      run_v[c] = 1'b1;
      run_id[c] = rdy_id[best];
      run_dl[c] = rdy_dl[best];
      run_rem[c] = rdy_rem[best];
      run_t0[c] = sh_now;
      rdy_v[best] = 1'b0;
      r.status = ST_DISPATCH;
      r.cpu = c[2:0];
      r.dispatched_id = rdy_id[best];
      r.last = 1'b0;
      sched_q.push_back(r);
      k++;
    end
    if (k > 0) sched_q[$].last = 1'b1;
  endfunction

  // Works out the results of one accepted event and queues them.
  function automatic void schedule_event(in_item_t e);
    int          s;
    bit          any_free;
    logic [31:0] fl, el, rem;
    out_item_t   r;
    case (kind_t'(e.kind))
      KIND_TICK: sh_now = sh_now + 32'd1;
      KIND_ARRIVE: begin
        s = open_slot();
        if (s < 0) begin
          r.status = ST_DROPPED;
          r.cpu = '0;
          r.dispatched_id = e.job_id;
          r.last = 1'b1;
          sched_q.push_back(r);
        end else begin
          rdy_v[s] = 1'b1;
          rdy_id[s] = e.job_id;
          rdy_dl[s] = e.job_deadline;
          rdy_rem[s] = e.job_duration;
          any_free = 1'b0;
          for (int c = 0; c < active_cpus(); c++) if (!run_v[c]) any_free = 1'b1;
          if (!any_free) begin
            fl = (sh_floor == 0) ? 32'd1 : 32'(sh_floor);
            for (int c = 0; c < active_cpus(); c++) begin
              if (!run_v[c]) continue;
              s = open_slot();
              if (s < 0) break;
              el = sh_now - run_t0[c];
              rem = (el >= run_rem[c]) ? fl : run_rem[c] - el;
              if (rem < fl) rem = fl;
              rdy_v[s] = 1'b1;
              rdy_id[s] = run_id[c];
              rdy_dl[s] = run_dl[c];
              rdy_rem[s] = rem;
              run_v[c] = 1'b0;
            end
          end
          run_dispatch();
        end
      end
      KIND_DONE: begin
        run_v[e.done_cpu] = 1'b0;
        run_dispatch();
      end
      default: ;
    endcase
  endfunction

  function automatic in_item_t make_event(logic [1:0] k, logic [7:0] id, logic [31:0] dl,
                                          logic [31:0] dur, logic [2:0] dc);
    in_item_t e;
    e.kind = k;
    e.job_id = id;
    e.job_deadline = dl;
    e.job_duration = dur;
    e.done_cpu = dc;
    return e;
  endfunction

  function automatic in_item_t random_event();
    int          p;
    logic [31:0] dl, dur;
    p = $urandom_range(99);
    dl = ($urandom_range(1)) ? 32'($urandom_range(0, 3000)) : $urandom;
    dur = ($urandom_range(2) != 0) ? 32'($urandom_range(1, 600)) : $urandom;
    if (dur == 0) dur = 1;
    if (p < 45) return make_event(KIND_ARRIVE, 8'($urandom), dl, dur, 3'($urandom));
    if (p < 72) return make_event(KIND_DONE, 8'($urandom), dl, dur,
                                  3'($urandom_range(0, active_cpus() - 1)));
    if (p < 80) return make_event(KIND_DONE, 8'($urandom), dl, dur, 3'($urandom));
    if (p < 96) return make_event(KIND_TICK, 8'($urandom), dl, dur, 3'($urandom));
    return make_event(KIND_NONE, 8'($urandom), $urandom, $urandom, 3'($urandom));
  endfunction

  // Request driver.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      start <= 1'b1;
    end else if (req_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
      in_req <= req_q.pop_front();
      start <= 1'b1;
    end else begin
      start <= 1'b0;
    end
  end

  // Result monitor and watchdog.
  always @(posedge clk) begin
    taken = 1'b0;
    if (rst_n) begin
      if (out_valid) begin
        if (sched_q.size() == 0) begin
          $error("unexpected result: status=%0d cpu=%0d id=%0d", out_res.status,
                 out_res.cpu, out_res.dispatched_id);
          errors++;
        end else begin
          out_item_t x;
          x = sched_q.pop_front();
          if (out_res.status !== x.status) begin
            $error("status: expected %0d, got %0d", x.status, out_res.status);
            errors++;
          end
          if (out_res.cpu !== x.cpu) begin
            $error("cpu: expected %0d, got %0d", x.cpu, out_res.cpu);
            errors++;
          end
          if (out_res.dispatched_id !== x.dispatched_id) begin
            $error("dispatched_id: expected %0d, got %0d", x.dispatched_id,
                   out_res.dispatched_id);
            errors++;
          end
          if (out_res.last !== x.last) begin
            $error("last: expected %0d, got %0d", x.last, out_res.last);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        schedule_event(in_req);
        taken = 1'b1;
      end
      if (taken || out_valid) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= STALL_MAX) begin
        $display("tb_least_slack_multi_cpu_scheduler_unit NOT OK");
        $finish;
      end
    end
  end

  task automatic drain();
    do @(negedge clk);
    while (req_q.size() > 0 || start || sched_q.size() > 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CPU_COUNT) sh_cpus = val[3:0];
    else sh_floor = val[9:0];
  endtask

  initial begin
    int cpu_set [5] = '{8, 3, 0, 15, 2};
    int floor_set [5] = '{1, 1000, 0, 1023, 5};
    int idle_set [5] = '{0, 59, 7, 59, 0};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed events at the reset configuration: one CPU, floor of ten.
    req_q.push_back(make_event(KIND_ARRIVE, 8'd0, 32'd0, 32'd1, 3'd0));
    req_q.push_back(make_event(KIND_TICK, 8'd0, 32'd0, 32'd0, 3'd0));
    req_q.push_back(make_event(KIND_ARRIVE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7));
    req_q.push_back(make_event(KIND_ARRIVE, 8'd5, 32'd20, 32'd100, 3'd0));
    req_q.push_back(make_event(KIND_DONE, 8'd0, 32'd0, 32'd0, 3'd0));
    req_q.push_back(make_event(KIND_DONE, 8'd0, 32'd0, 32'd0, 3'd7));
    req_q.push_back(make_event(KIND_NONE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7));
    req_q.push_back(make_event(KIND_TICK, 8'd0, 32'd0, 32'd0, 3'd0));
    req_q.push_back(make_event(KIND_ARRIVE, 8'd9, 32'd0, 32'hFFFF_FFFF, 3'd0));
    req_q.push_back(make_event(KIND_DONE, 8'd0, 32'd0, 32'd0, 3'd0));
    req_q.push_back(make_event(KIND_DONE, 8'd0, 32'd0, 32'd0, 3'd0));
    req_q.push_back(make_event(KIND_DONE, 8'd0, 32'd0, 32'd0, 3'd0));
    drain();

    // Random phases, each with its own configuration and sender gap rate.
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_CPU_COUNT, CfgDataW'(cpu_set[ph]));
      write_reg(CFG_MIN_REM, CfgDataW'(floor_set[ph]));
      idle_pct = idle_set[ph];
      for (int i = 0; i < 14; i++) req_q.push_back(random_event());
      // Arrival bursts push the ready table to full so that drops occur.
      if (ph == 1 || ph == 3)
        for (int i = 0; i < 20; i++)
          req_q.push_back(make_event(KIND_ARRIVE, 8'($urandom), $urandom,
                                     32'($urandom_range(1, 50)), 3'd0));
      drain();
    end

    if (errors == 0) begin
      $display("tb_least_slack_multi_cpu_scheduler_unit OK");
    end else begin
      $display("tb_least_slack_multi_cpu_scheduler_unit NOT OK");
    end
    $finish;
  end

endmodule
